/* design/osp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package osp_pkg;
  localparam int STASH_SLOTS = 32;
  localparam int BLOCK_WORDS = 64;
  localparam int NODE_BITS   = 16;

  localparam int SLOT_W    = (STASH_SLOTS > 1) ? $clog2(STASH_SLOTS) : 1;
  localparam int WORD_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int LEN_W     = $clog2(BLOCK_WORDS + 1);
  localparam int LBL_W     = NODE_BITS + 1;
  localparam int MSB_W     = $clog2(LBL_W);
  localparam int MEM_DEPTH = STASH_SLOTS * BLOCK_WORDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DATA_W    = 64;
  localparam int ID_W      = 16;
  localparam int LABEL_W   = 16;
  localparam int SIDX_W    = 5;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EVICTED  = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef enum logic [1:0] {
    CMD_INS,
    CMD_FULL,
    CMD_EVICT,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  word;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  data;
  } cmd_t;

  function automatic logic [MSB_W-1:0] msb_pos(input logic [LBL_W-1:0] v);
    logic [MSB_W-1:0] p;
    p = '0;
    for (int i = 0; i < LBL_W; i++) begin
      if (v[i]) p = MSB_W'(i);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

/* design/oram_stash_path_eviction_core.sv */
// insert word: one result, passed through the command queue, the read stage and the result queue
// evict: BLOCK_WORDS result beats of one word each, through the command queue, evict state, read stage, result queue
// throughput set by the payload memory port: one insert or evicted word per cycle while the result queue has room
// not found and stash full give a single result each; a 4-deep command queue decouples the sides
// synchronous reset empties the stash and both queues; payload memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
module oram_stash_path_eviction_core import osp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               op,
  input  wire logic [ID_W-1:0]    blk_id,
  input  wire logic [LABEL_W-1:0] leaf,
  input  wire logic [LABEL_W-1:0] node,
  input  wire logic [DATA_W-1:0]  data_word,
  input  wire logic               last_word,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              status,
  output logic [SIDX_W-1:0]       slot_index,
  output logic [ID_W-1:0]         out_blk_id,
  output logic [DATA_W-1:0]       out_data,
  output logic                    out_last
);
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  osp_front u_front (
    .clk, .rst, .accept, .op, .blk_id, .leaf, .node, .data_word, .last_word,
    .cmd(cmd_in)
  );

  osp_cmd_fifo u_cmdq (
    .clk, .rst, .push(accept), .din(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .empty(cmd_empty), .dout(cmd_out)
  );

  osp_back u_back (
    .clk, .rst, .cmd_empty, .cmd(cmd_out), .cmd_pop, .pop, .empty,
    .status, .slot_index, .out_blk_id, .out_data, .out_last
  );
endmodule
`default_nettype wire

/* design/osp_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module osp_cmd_fifo import osp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      dout
);
  cmd_t entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
    if (do_push) entries[wr_ptr] <= din;
  end
endmodule
`default_nettype wire

/* design/osp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module osp_front import osp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic               op,
  input  wire logic [ID_W-1:0]    blk_id,
  input  wire logic [LABEL_W-1:0] leaf,
  input  wire logic [LABEL_W-1:0] node,
  input  wire logic [DATA_W-1:0]  data_word,
  input  wire logic               last_word,
  output cmd_t                    cmd
);
  logic                slot_valid [STASH_SLOTS];
  logic [ID_W-1:0]     slot_id    [STASH_SLOTS];
  logic [LBL_W-1:0]    slot_lp1   [STASH_SLOTS];
  logic [MSB_W-1:0]    slot_lmsb  [STASH_SLOTS];
  logic [LEN_W-1:0]    slot_len   [STASH_SLOTS];
  logic                fill_busy;
  logic [SLOT_W-1:0]   fill_slot;
  logic [WORD_W-1:0]   fill_cnt;

  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic                hit_found;
  logic [SLOT_W-1:0]   hit_idx;
  logic [STASH_SLOTS-1:0] hit;
  logic [LBL_W-1:0]    np1;
  logic [MSB_W-1:0]    nmsb;
  logic [LBL_W-1:0]    lp1;
  logic [SLOT_W-1:0]   ins_slot;
  logic [WORD_W-1:0]   ins_word;
  logic                closes;

  assign np1      = LBL_W'(node[NODE_BITS-1:0]) + 1'b1;
  assign nmsb     = msb_pos(np1);
  assign lp1      = LBL_W'(leaf[NODE_BITS-1:0]) + 1'b1;
  assign ins_slot = fill_busy ? fill_slot : free_idx;
  assign ins_word = fill_busy ? fill_cnt : '0;
  assign closes   = last_word || (ins_word == WORD_W'(BLOCK_WORDS - 1));

  // node is an ancestor when its 1-based label is a prefix of the leaf's
  always_comb begin
    for (int s = 0; s < STASH_SLOTS; s++) begin
      hit[s] = slot_valid[s] && (slot_lmsb[s] >= nmsb) &&
               ((slot_lp1[s] >> (slot_lmsb[s] - nmsb)) == np1);
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int s = STASH_SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid[s]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(s);
      end
      if (hit[s]) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.data = data_word;
    if (!op) begin
      if (!fill_busy && !free_found) begin
        cmd.kind = CMD_FULL;
      end else begin
        cmd.kind = CMD_INS;
        cmd.slot = ins_slot;
        cmd.word = ins_word;
      end
    end else if (hit_found) begin
      cmd.kind = CMD_EVICT;
      cmd.slot = hit_idx;
      cmd.id   = slot_id[hit_idx];
      cmd.len  = slot_len[hit_idx];
    end else begin
      cmd.kind = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STASH_SLOTS; s++) slot_valid[s] <= 1'b0;
      fill_busy <= 1'b0;
      fill_slot <= '0;
      fill_cnt  <= '0;
    end else if (accept) begin
      if (!op) begin
        if (fill_busy || free_found) begin
          if (closes) begin
            slot_valid[ins_slot] <= 1'b1;
            slot_id[ins_slot]    <= blk_id;
            slot_lp1[ins_slot]   <= lp1;
            slot_lmsb[ins_slot]  <= msb_pos(lp1);
            slot_len[ins_slot]   <= LEN_W'(ins_word) + 1'b1;
            fill_busy <= 1'b0;
            fill_cnt  <= '0;
          end else begin
            fill_busy <= 1'b1;
            fill_slot <= ins_slot;
            fill_cnt  <= ins_word + 1'b1;
          end
        end
      end else if (hit_found) begin
        slot_valid[hit_idx] <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* design/osp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module osp_back import osp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cmd_empty,
  input  wire cmd_t         cmd,
  output logic              cmd_pop,
  input  wire logic         pop,
  output logic              empty,
  output logic [1:0]        status,
  output logic [SIDX_W-1:0] slot_index,
  output logic [ID_W-1:0]   out_blk_id,
  output logic [DATA_W-1:0] out_data,
  output logic              out_last
);
  typedef struct packed {
    logic [1:0]        status;
    logic [SIDX_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [DATA_W-1:0] mem_q;

  logic              busy;
  logic [SLOT_W-1:0] ev_slot;
  logic [ID_W-1:0]   ev_id;
  logic [LEN_W-1:0]  ev_len;
  logic [WORD_W-1:0] ev_w;

  logic              rd_v;
  logic              rd_use_mem;
  logic [1:0]        rd_status;
  logic [SIDX_W-1:0] rd_slot;
  logic [ID_W-1:0]   rd_id;
  logic              rd_last;

  res_t       ores [4];
  logic [1:0] owr;
  logic [1:0] ord;
  logic [2:0] ocount;
  logic       opop;
  logic       room;
  logic       ev_final;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  res_t       ores_in;

  // leave a place for the beat already in the read stage
  assign room     = ({1'b0, ocount} + {3'b0, rd_v}) < 4'd4;
  assign ev_final = (ev_w == WORD_W'(BLOCK_WORDS - 1));
  assign rd_addr  = ADDR_W'(ev_slot) * ADDR_W'(BLOCK_WORDS) + ADDR_W'(ev_w);
  assign wr_addr  = ADDR_W'(cmd.slot) * ADDR_W'(BLOCK_WORDS) + ADDR_W'(cmd.word);
  assign cmd_pop  = room && !busy && !cmd_empty;
  assign empty    = (ocount == '0);
  assign opop     = pop && !empty;

  assign ores_in.status = rd_status;
  assign ores_in.slot   = rd_slot;
  assign ores_in.id     = rd_id;
  assign ores_in.data   = rd_use_mem ? mem_q : '0;
  assign ores_in.last   = rd_last;

  assign status       = ores[ord].status;
  assign slot_index   = ores[ord].slot;
  assign out_blk_id   = ores[ord].id;
  assign out_data     = ores[ord].data;
  assign out_last     = ores[ord].last;

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (cmd_pop && cmd.kind == CMD_INS) mem[wr_addr] <= cmd.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      rd_v   <= 1'b0;
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      rd_v <= 1'b0;
      if (room && busy) begin
        rd_v       <= 1'b1;
        rd_status  <= ST_EVICTED;
        rd_slot    <= SIDX_W'(ev_slot);
        rd_id      <= ev_id;
        rd_last    <= ev_final;
        // words past the end of a short block read as zero
        rd_use_mem <= (LEN_W'(ev_w) < ev_len);
        ev_w       <= ev_w + 1'b1;
        if (ev_final) busy <= 1'b0;
      end else if (cmd_pop) begin
        rd_use_mem <= 1'b0;
        rd_id      <= '0;
        rd_last    <= 1'b1;
        unique case (cmd.kind)
          CMD_INS: begin
            rd_v      <= 1'b1;
            rd_status <= ST_INSERTED;
            rd_slot   <= SIDX_W'(cmd.slot);
          end
          CMD_FULL: begin
            rd_v      <= 1'b1;
            rd_status <= ST_FULL;
            rd_slot   <= '0;
          end
          CMD_NONE: begin
            rd_v      <= 1'b1;
            rd_status <= ST_NONE;
            rd_slot   <= '0;
          end
          CMD_EVICT: begin
            busy    <= 1'b1;
            ev_slot <= cmd.slot;
            ev_id   <= cmd.id;
            ev_len  <= cmd.len;
            ev_w    <= '0;
          end
          default: ;
        endcase
      end
      if (rd_v) owr <= owr + 1'b1;
      if (opop) ord <= ord + 1'b1;
      if (rd_v && !opop) ocount <= ocount + 1'b1;
      else if (opop && !rd_v) ocount <= ocount - 1'b1;
    end
    if (rd_v) ores[owr] <= ores_in;
  end
endmodule
`default_nettype wire

/* design/osp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module osp_checker import osp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [1:0]        status,
  input wire logic [SIDX_W-1:0] slot_index,
  input wire logic [ID_W-1:0]   out_blk_id,
  input wire logic [DATA_W-1:0] out_data,
  input wire logic              out_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(out_data)))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results pending after reset");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_EVICTED) |-> out_last)
    else $error("non-eviction result without last mark");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_EVICTED) |-> (out_data == '0 && out_blk_id == '0))
    else $error("non-eviction result carries data");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == ST_FULL || status == ST_NONE)) |-> (slot_index == '0))
    else $error("status without slot shows a slot");
endmodule

bind oram_stash_path_eviction_core osp_checker u_osp_checker (
  .clk, .rst, .empty, .pop, .status, .slot_index, .out_blk_id, .out_data, .out_last
);
`default_nettype wire
